@@ src/b64_pkg.sv @@
// ----------------------------------------------------------------------------
// b64_pkg
// Shared types, constants and the alphabet lookup of the Base64 line encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package b64_pkg;

  // characters per line before CR LF (4 .. 124)
  localparam logic [6:0] LineChars = 7'd76;

  // depth of the queue between front and back end, a power of two
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);

  localparam logic [7:0] ChCr  = 8'd13;
  localparam logic [7:0] ChLf  = 8'd10;
  localparam logic [7:0] ChPad = 8'd61;

  // one queued word: up to four characters for a single input byte
  typedef struct packed {
    logic [3:0][7:0] chars;
    logic [1:0]      last_idx;  // index of the final valid character
    logic            msg_end;   // final character closes the message
  } b64_entry_t;

  function automatic logic [7:0] b64_sym(input logic [5:0] v);
    logic [7:0] r;
    if (v < 6'd26) begin
      r = 8'd65 + {2'b00, v};
    end else if (v < 6'd52) begin
      r = 8'd71 + {2'b00, v};        // 'a' - 26
    end else if (v < 6'd62) begin
      r = {2'b00, v} - 8'd4;         // '0' + (v - 52)
    end else if (v == 6'd62) begin
      r = 8'd43;                     // '+'
    end else begin
      r = 8'd47;                     // '/'
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ src/b64_front.sv @@
// ----------------------------------------------------------------------------
// b64_front
// Takes input bytes, tracks group phase, leftover bits and line position,
// and builds the characters each byte produces as one queue word.
// ----------------------------------------------------------------------------
`default_nettype none

module b64_front import b64_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  output b64_entry_t entry_o
);

  logic [1:0] phase_q, phase_d;
  logic [3:0] held_q, held_d;
  logic [6:0] line_q, line_d;
  logic [6:0] line_sum;

  assign line_sum = line_q + 7'd4;

  always_comb begin
    entry_o  = '0;
    phase_d  = phase_q;
    held_d   = held_q;
    line_d   = line_q;
    case (phase_q)
      2'd1: begin
        entry_o.chars[0] = b64_sym({held_q[1:0], data_byte_i[7:4]});
        held_d  = data_byte_i[3:0];
        phase_d = 2'd2;
        if (last_byte_i) begin
          entry_o.chars[1] = b64_sym({data_byte_i[3:0], 2'b00});
          entry_o.chars[2] = ChPad;
          entry_o.last_idx = 2'd2;
        end
      end
      2'd2: begin
        entry_o.chars[0] = b64_sym({held_q, data_byte_i[7:6]});
        entry_o.chars[1] = b64_sym(data_byte_i[5:0]);
        entry_o.last_idx = 2'd1;
        held_d  = '0;
        phase_d = 2'd0;
        if (line_sum >= LineChars) begin
          entry_o.chars[2] = ChCr;
          entry_o.chars[3] = ChLf;
          entry_o.last_idx = 2'd3;
          line_d = '0;
        end else begin
          line_d = line_sum;
        end
      end
      default: begin
        // phase 3 never arises; treated as start of group
        entry_o.chars[0] = b64_sym(data_byte_i[7:2]);
        held_d  = {2'b00, data_byte_i[1:0]};
        phase_d = 2'd1;
        if (last_byte_i) begin
          entry_o.chars[1] = b64_sym({data_byte_i[1:0], 4'b0000});
          entry_o.chars[2] = ChPad;
          entry_o.chars[3] = ChPad;
          entry_o.last_idx = 2'd3;
        end
      end
    endcase
    entry_o.msg_end = last_byte_i;
    if (last_byte_i) begin
      phase_d = '0;
      held_d  = '0;
      line_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      held_q  <= '0;
      line_q  <= '0;
    end else if (push_i) begin
      phase_q <= phase_d;
      held_q  <= held_d;
      line_q  <= line_d;
    end
  end

endmodule

`default_nettype wire

@@ src/b64_queue.sv @@
// ----------------------------------------------------------------------------
// b64_queue
// Short word queue between front and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module b64_queue import b64_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  b64_entry_t push_entry_i,
  output logic       full_o,
  input  logic       pop_i,
  output logic       head_valid_o,
  output b64_entry_t head_entry_o
);

  localparam int unsigned CntW = QueuePtrW + 1;

  b64_entry_t mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]      cnt_q, cnt_d;

  assign full_o       = (cnt_q == CntW'(QueueDepth));
  assign head_valid_o = (cnt_q != '0);
  assign head_entry_o = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ src/b64_back.sv @@
// ----------------------------------------------------------------------------
// b64_back
// Walks the head queue word onto out_char_o one character per ready cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module b64_back import b64_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       head_valid_i,
  input  b64_entry_t head_entry_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_char_o,
  output logic       last_char_o
);

  logic [1:0] idx_q, idx_d;
  logic       fire;
  logic       at_end;

  assign out_valid_o = head_valid_i;
  assign out_char_o  = head_entry_i.chars[idx_q];
  assign at_end      = (idx_q == head_entry_i.last_idx);
  assign last_char_o = head_entry_i.msg_end && at_end;
  assign fire        = head_valid_i && out_ready_i;
  assign pop_o       = fire && at_end;

  always_comb begin
    idx_d = idx_q;
    if (fire) begin
      idx_d = at_end ? 2'd0 : idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

endmodule

`default_nettype wire

@@ src/base64_encoder_line_wrap.sv @@
// ----------------------------------------------------------------------------
// base64_encoder_line_wrap
// Streaming Base64 encoder with CR LF line wrapping and '=' padding.
// ----------------------------------------------------------------------------
//   channel | direction | handshake                 | payload
//   in      | input     | in_valid_i / in_ready_o   | data_byte_i, last_byte_i
//   out     | output    | out_valid_o / out_ready_i | out_char_o, last_char_o
//
// A byte is taken every cycle while the word queue has room; each byte
// becomes one word of 1 to 4 characters, sent at one character per cycle
// while out_ready_i is high, so the output port sets the sustained rate.
// A word is registered in the queue before it is sent. Reset empties the
// queue and clears group phase, leftover bits and line position.
// Either side may stall without blocking the other until the queue fills.
// ----------------------------------------------------------------------------
`default_nettype none

module base64_encoder_line_wrap import b64_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_char_o,
  output logic       last_char_o
);

  b64_entry_t new_entry;
  b64_entry_t head_entry;
  logic       push;
  logic       full;
  logic       pop;
  logic       head_valid;

  assign in_ready_o = !full;
  assign push       = in_valid_i && !full;

  b64_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .entry_o     (new_entry)
  );

  b64_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (new_entry),
    .full_o       (full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_entry_o (head_entry)
  );

  b64_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_entry_i (head_entry),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_char_o   (out_char_o),
    .last_char_o  (last_char_o)
  );

endmodule

`default_nettype wire
